// File: src/grot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package grot_pkg;

  // Default arithmetic configuration.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 30;

  // Fixed field widths of the stream items.
  localparam int XY_W        = 32;
  localparam int MAT_W       = 32;
  localparam int NORM_W      = 33;
  localparam int IN_TDATA_W  = 2 * XY_W;
  localparam int OUT_FIELD_W = 4 * MAT_W + NORM_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: src/grot_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined digit-by-digit square root of (in_sum << 2*FRAC_BITS).
// One root bit is resolved in each stage.
module grot_isqrt #(
  parameter int DATA_WIDTH = grot_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = grot_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [2*DATA_WIDTH-1:0]   in_sum,
  input  wire logic [SIDE_W-1:0]         in_side,
  output logic                           out_valid,
  output logic [DATA_WIDTH+FRAC_BITS-1:0] out_root,
  output logic [SIDE_W-1:0]              out_side
);

  localparam int N = DATA_WIDTH + FRAC_BITS;

  logic                    v_r    [N];
  logic [N-1:0]            root_r [N];
  logic [N+1:0]            rem_r  [N];
  logic [2*DATA_WIDTH-1:0] sum_r  [N];
  logic [SIDE_W-1:0]       side_r [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;
    logic                    vi;
    logic [N-1:0]            ri;
    logic [N+1:0]            mi;
    logic [2*DATA_WIDTH-1:0] si;
    logic [SIDE_W-1:0]       di;
    logic [1:0]              pair;
    logic [N+3:0]            rs;
    logic [N+3:0]            trial;
    logic [N+3:0]            df;
    logic [N+1:0]            rem_nxt;
    logic [N-1:0]            root_nxt;

    if (j == 0) begin : g_first
      assign vi = in_valid;
      assign ri = '0;
      assign mi = '0;
      assign si = in_sum;
      assign di = in_side;
    end else begin : g_next
      assign vi = v_r[j-1];
      assign ri = root_r[j-1];
      assign mi = rem_r[j-1];
      assign si = sum_r[j-1];
      assign di = side_r[j-1];
    end

    // The low 2*FRAC_BITS bits of the radicand are zero.
    if (K >= FRAC_BITS) begin : g_pair
      assign pair = si[2*(K-FRAC_BITS)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rs    = {mi, pair};
    assign trial = {2'b00, ri, 2'b01};
    assign df    = rs - trial;

    always_comb begin
      if (rs >= trial) begin
        rem_nxt  = df[N+1:0];
        root_nxt = {ri[N-2:0], 1'b1};
      end else begin
        rem_nxt  = rs[N+1:0];
        root_nxt = {ri[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= root_nxt;
        rem_r[j]  <= rem_nxt;
        sum_r[j]  <= si;
        side_r[j] <= di;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

`default_nettype wire

// File: src/grot_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Two pipelined restoring dividers sharing one divisor. Each computes
// floor((a << 2*FRAC_BITS) / q) one quotient bit per stage; a*2^FRAC_BITS <= q
// holds, so the quotient has FRAC_BITS+1 bits.
module grot_div #(
  parameter int DATA_WIDTH = grot_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = grot_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [DATA_WIDTH+FRAC_BITS-1:0] in_q,
  input  wire logic [DATA_WIDTH-1:0]        in_a,
  input  wire logic [DATA_WIDTH-1:0]        in_b,
  input  wire logic [SIDE_W-1:0]            in_side,
  output logic                              out_valid,
  output logic [DATA_WIDTH+FRAC_BITS-1:0]   out_q,
  output logic [FRAC_BITS:0]                out_qa,
  output logic [FRAC_BITS:0]                out_qb,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int N = DATA_WIDTH + FRAC_BITS;
  localparam int S = FRAC_BITS + 1;

  logic               v_r    [S];
  logic [N-1:0]       q_r    [S];
  logic [N-1:0]       ra_r   [S];
  logic [N-1:0]       rb_r   [S];
  logic [FRAC_BITS:0] qa_r   [S];
  logic [FRAC_BITS:0] qb_r   [S];
  logic [SIDE_W-1:0]  side_r [S];

  for (genvar j = 0; j < S; j++) begin : g_stage
    logic               vi;
    logic [N-1:0]       qi;
    logic [N-1:0]       rai;
    logic [N-1:0]       rbi;
    logic [FRAC_BITS:0] qai;
    logic [FRAC_BITS:0] qbi;
    logic [SIDE_W-1:0]  di;
    logic [N:0]         ta;
    logic [N:0]         tb;
    logic [N:0]         qx;
    logic [N:0]         da;
    logic [N:0]         db;
    logic               ga;
    logic               gb;

    if (j == 0) begin : g_first
      assign vi  = in_valid;
      assign qi  = in_q;
      assign rai = {1'b0, in_a, {(FRAC_BITS-1){1'b0}}};
      assign rbi = {1'b0, in_b, {(FRAC_BITS-1){1'b0}}};
      assign qai = '0;
      assign qbi = '0;
      assign di  = in_side;
    end else begin : g_next
      assign vi  = v_r[j-1];
      assign qi  = q_r[j-1];
      assign rai = ra_r[j-1];
      assign rbi = rb_r[j-1];
      assign qai = qa_r[j-1];
      assign qbi = qb_r[j-1];
      assign di  = side_r[j-1];
    end

    assign ta = {rai, 1'b0};
    assign tb = {rbi, 1'b0};
    assign qx = {1'b0, qi};
    assign da = ta - qx;
    assign db = tb - qx;
    assign ga = (ta >= qx);
    assign gb = (tb >= qx);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]    <= qi;
        ra_r[j]   <= ga ? da[N-1:0] : ta[N-1:0];
        rb_r[j]   <= gb ? db[N-1:0] : tb[N-1:0];
        qa_r[j]   <= {qai[FRAC_BITS-1:0], ga};
        qb_r[j]   <= {qbi[FRAC_BITS-1:0], gb};
        side_r[j] <= di;
      end
    end
  end

  assign out_valid = v_r[S-1];
  assign out_q     = q_r[S-1];
  assign out_qa    = qa_r[S-1];
  assign out_qb    = qb_r[S-1];
  assign out_side  = side_r[S-1];

endmodule

`default_nettype wire

// File: src/givens_rotation_2x2_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | tdata fields, lowest bit first
// in_     | slave     | x_value[31:0], y_value[63:32]
// out_    | master    | top_left, top_right, bottom_left, bottom_right, norm_or_x (33), pad
//
// One item is accepted per cycle while no result waits on out_tready; the pipeline is
// made of three input stages, the square root (one root bit per stage), the two
// dividers (one quotient bit per stage) and the output register.
// Reset clears only the valid bits.
// The whole pipeline holds while a result waits on out_tready; an item enters
// whenever the output register is empty or being taken.
module givens_rotation_2x2_unit #(
  parameter int DATA_WIDTH = grot_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = grot_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // x_value, y_value
  input  wire logic [grot_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // top_left, top_right, bottom_left, bottom_right, norm_or_x, zero pad
  output logic [grot_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int W      = DATA_WIDTH;
  localparam int N      = DATA_WIDTH + FRAC_BITS;
  localparam int XY_W   = grot_pkg::XY_W;
  localparam int MAT_W  = grot_pkg::MAT_W;
  localparam int NORM_W = grot_pkg::NORM_W;
  localparam int PAD_W  = grot_pkg::OUT_TDATA_W - grot_pkg::OUT_FIELD_W;
  localparam int DSIDE_W = W + 3;
  localparam int SSIDE_W = 2 * W + DSIDE_W;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Input magnitudes and signs.
  logic signed [W-1:0] x_in;
  logic signed [W-1:0] y_in;
  assign x_in = in_tdata[W-1:0];
  assign y_in = in_tdata[XY_W+W-1:XY_W];

  logic             v1_r;
  logic [W-1:0]     ax1_r;
  logic [W-1:0]     ay1_r;
  logic [DSIDE_W-1:0] ds1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= x_in[W-1] ? (W)'(-x_in) : x_in;
      ay1_r <= y_in[W-1] ? (W)'(-y_in) : y_in;
      ds1_r <= {x_in[W-1], y_in[W-1], (y_in == '0), x_in};
    end
  end

  // Squares.
  logic             v2_r;
  logic [2*W-1:0]   sx2_r;
  logic [2*W-1:0]   sy2_r;
  logic [W-1:0]     ax2_r;
  logic [W-1:0]     ay2_r;
  logic [DSIDE_W-1:0] ds2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx2_r <= ax1_r * ax1_r;
      sy2_r <= ay1_r * ay1_r;
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      ds2_r <= ds1_r;
    end
  end

  // Sum of squares; at most 2^(2W-1), so it fits 2W bits.
  logic             v3_r;
  logic [2*W-1:0]   sum3_r;
  logic [SSIDE_W-1:0] ss3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r <= sx2_r + sy2_r;
      ss3_r  <= {ax2_r, ay2_r, ds2_r};
    end
  end

  logic               sq_valid;
  logic [N-1:0]       sq_root;
  logic [SSIDE_W-1:0] sq_side;

  grot_isqrt #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_W     (SSIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_sum    (sum3_r),
    .in_side   (ss3_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic               dv_valid;
  logic [N-1:0]       dv_q;
  logic [FRAC_BITS:0] dv_c;
  logic [FRAC_BITS:0] dv_s;
  logic [DSIDE_W-1:0] dv_side;

  grot_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_W     (DSIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_q      (sq_root),
    .in_a      (sq_side[SSIDE_W-1 -: W]),
    .in_b      (sq_side[SSIDE_W-W-1 -: W]),
    .in_side   (sq_side[DSIDE_W-1:0]),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_qa    (dv_c),
    .out_qb    (dv_s),
    .out_side  (dv_side)
  );

  // Output formatting.
  logic                x_neg;
  logic                y_neg;
  logic                y_zero;
  logic signed [W-1:0] x_pass;
  logic [MAT_W-1:0]    c_mag;
  logic [MAT_W-1:0]    s_mag;
  logic [MAT_W-1:0]    c_val;
  logic [MAT_W-1:0]    s_val;
  logic [MAT_W-1:0]    ns_val;
  logic [NORM_W-1:0]   norm_val;

  assign x_neg  = dv_side[W+2];
  assign y_neg  = dv_side[W+1];
  assign y_zero = dv_side[W];
  assign x_pass = dv_side[W-1:0];
  assign c_mag  = MAT_W'(dv_c);
  assign s_mag  = MAT_W'(dv_s);

  always_comb begin
    if (y_zero) begin
      c_val    = MAT_W'(1) << FRAC_BITS;
      s_val    = '0;
      ns_val   = '0;
      norm_val = NORM_W'(x_pass);
    end else begin
      c_val    = x_neg ? (MAT_W'(0) - c_mag) : c_mag;
      s_val    = y_neg ? (MAT_W'(0) - s_mag) : s_mag;
      ns_val   = y_neg ? s_mag : (MAT_W'(0) - s_mag);
      norm_val = NORM_W'(dv_q[N-1:FRAC_BITS]);
    end
  end

  logic                          out_valid_r;
  logic [grot_pkg::OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {{PAD_W{1'b0}}, norm_val, c_val, ns_val, s_val, c_val};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
